[hdl/sm4m_pkg.sv]
// SM4 cipher package: S-box, FK/CK constants, chaining mode and status codes.
// Used by sm4_block_cipher_modes; no other dependencies.
`default_nettype none
package sm4m_pkg;

   localparam int RoundCount = 32;
   localparam int RkIdxWidth = 5;

   // chaining mode codes
   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_OFB = 2'd2;
   localparam logic [1:0] MODE_BAD = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_PARTIAL = 2'd1;
   localparam logic [1:0] STAT_MODE    = 2'd2;

   // register indexes
   localparam logic [2:0] REG_KEY_HIGH = 3'd0;
   localparam logic [2:0] REG_KEY_LOW  = 3'd1;
   localparam logic [2:0] REG_IV_HIGH  = 3'd2;
   localparam logic [2:0] REG_IV_LOW   = 3'd3;
   localparam logic [2:0] REG_MODE     = 3'd4;
   localparam logic [2:0] REG_DECRYPT  = 3'd5;

   localparam logic [31:0] FK0 = 32'hA3B1BAC6;
   localparam logic [31:0] FK1 = 32'h56AA3350;
   localparam logic [31:0] FK2 = 32'h677D9197;
   localparam logic [31:0] FK3 = 32'hB27022DC;

   typedef logic [7:0] sbox_arr_type [256];
   localparam sbox_arr_type SBOX = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // byte-wise S-box over a word
   function automatic logic [31:0] subst(input logic [31:0] x);
      subst = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   // CK word i: byte j is (4i+j)*7 mod 256
   function automatic logic [31:0] ck_word(input logic [4:0] i);
      logic [7:0] b0;
      b0 = {1'b0, i, 2'b00} * 8'd7;
      ck_word = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
   endfunction

   // mask keeping the leading n bytes (0..8) of a big-endian half
   function automatic logic [63:0] lead_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < n) begin
            m[63 - 8*b -: 8] = 8'hff;
         end
      end
      lead_mask = m;
   endfunction

endpackage
`default_nettype wire

[hdl/sm4_block_cipher_modes.sv]
// SM4 block cipher top level: ECB, CBC and OFB chaining, one shared round unit.
// Depends on sm4m_pkg and sm4m_ram.
//
// Each request item is one 128-bit block; one response item follows it. The
// block runs one SM4 round per clock through a single round unit, reading the
// round keys from a 32-entry RAM. A block passes a key-read prefetch step, 32
// rounds and a chaining step before its response is valid. After a write to
// either key register the next block first runs the key schedule through the
// same unit. Items that are rejected (invalid mode, partial block outside OFB)
// respond in the next cycle. The block accepts no request while an item is in
// work or its response is unclaimed.
`default_nettype none
module sm4_block_cipher_modes (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [63:0] block_high, [127:64] block_low, [132:128] valid_bytes, [135:133] zero
   input  wire logic [135:0] req_tdata,
   input  wire logic         req_tuser,      // first_block
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [63:0] result_high, [127:64] result_low, [132:128] result_bytes,
   // [134:133] status, [135] zero
   output logic      [135:0] rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   import sm4m_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_KPRE  = 3'd1;
   localparam logic [2:0] ST_KEXP  = 3'd2;
   localparam logic [2:0] ST_RPRE  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [1:0]  mode_ff;
   logic        dec_ff;
   logic        keys_ready_ff, keys_ready_in;
   logic [63:0] chain_hi_ff, chain_hi_in, chain_lo_ff, chain_lo_in;
   logic [31:0] x_ff [4];
   logic [31:0] x_in [4];
   logic [63:0] blk_hi_ff, blk_lo_ff;
   logic [4:0]  nb_ff;
   logic [135:0] rsp_ff, rsp_in;
   logic [4:0]  nb_sat;

   // round key RAM
   logic        rk_we;
   logic [RkIdxWidth-1:0] rk_waddr, rk_raddr;
   logic [31:0] rk_wdata, rk_rdata;

   sm4m_ram #(.Width(32), .Depth(RoundCount)) u_rk_ram (
      .clock(clock), .wr_en(rk_we), .wr_addr(rk_waddr), .wr_data(rk_wdata),
      .rd_addr(rk_raddr), .rd_data(rk_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = rsp_ff;
   assign csr_ready  = 1'b1;

   wire accept = req_tvalid && req_tready;
   wire kwrite = csr_valid && (csr_index == REG_KEY_HIGH || csr_index == REG_KEY_LOW);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0; key_low_ff <= '0; iv_high_ff <= '0; iv_low_ff <= '0;
         mode_ff <= MODE_ECB; dec_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_data;
            REG_KEY_LOW:  key_low_ff  <= csr_data;
            REG_IV_HIGH:  iv_high_ff  <= csr_data;
            REG_IV_LOW:   iv_low_ff   <= csr_data;
            REG_MODE:     mode_ff     <= csr_data[1:0];
            REG_DECRYPT:  dec_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // shared round unit: one S-box step serves key schedule and data rounds, each with its own linear transform
   logic        is_key;
   logic [31:0] rk_sel, t_word, l_word, new_word;
   always_comb begin
      is_key   = (state_ff == ST_KEXP);
      rk_sel   = is_key ? ck_word(cnt_ff) : rk_rdata;
      t_word   = subst(x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ rk_sel);
      if (is_key) begin
         l_word = t_word ^ {t_word[18:0], t_word[31:19]} ^ {t_word[8:0], t_word[31:9]};
      end else begin
         l_word = t_word ^ {t_word[29:0], t_word[31:30]} ^ {t_word[21:0], t_word[31:22]}
                ^ {t_word[13:0], t_word[31:14]} ^ {t_word[7:0], t_word[31:8]};
      end
      new_word = x_ff[0] ^ l_word;
   end

   assign nb_sat = (req_tdata[132:128] > 5'd16) ? 5'd16 : req_tdata[132:128];

   // reverse key order for ECB/CBC decrypt
   wire rev = dec_ff && (mode_ff != MODE_OFB);

   // sequencer
   logic [127:0] ofb_ks;
   logic [63:0]  res_hi, res_lo;
   logic [127:0] out_blk;
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_ready_in = keys_ready_ff;
      chain_hi_in   = chain_hi_ff;
      chain_lo_in   = chain_lo_ff;
      x_in          = x_ff;
      rsp_in        = rsp_ff;
      rk_we         = 1'b0;
      rk_waddr      = cnt_ff;
      rk_wdata      = new_word;
      rk_raddr      = rev ? ~cnt_ff : cnt_ff;
      out_blk       = {x_ff[3], x_ff[2], x_ff[1], x_ff[0]};
      ofb_ks        = out_blk;
      res_hi        = '0;
      res_lo        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (mode_ff == MODE_BAD) begin
                  rsp_in   = {1'b0, STAT_MODE, 5'd0, 128'd0};
                  state_in = ST_OUT;
               end else if (mode_ff != MODE_OFB && nb_sat != 5'd16) begin
                  rsp_in   = {1'b0, STAT_PARTIAL, 5'd0, 128'd0};
                  state_in = ST_OUT;
               end else begin
                  if (req_tuser) begin
                     chain_hi_in = iv_high_ff;
                     chain_lo_in = iv_low_ff;
                  end
                  cnt_in   = '0;
                  state_in = keys_ready_ff ? ST_RPRE : ST_KPRE;
               end
            end
         end
         ST_KPRE: begin
            x_in[0] = key_high_ff[63:32] ^ FK0;
            x_in[1] = key_high_ff[31:0]  ^ FK1;
            x_in[2] = key_low_ff[63:32]  ^ FK2;
            x_in[3] = key_low_ff[31:0]   ^ FK3;
            state_in = ST_KEXP;
         end
         ST_KEXP: begin
            rk_we = 1'b1;
            x_in  = '{x_ff[1], x_ff[2], x_ff[3], new_word};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(RoundCount - 1)) begin
               keys_ready_in = 1'b1;
               state_in      = ST_RPRE;
            end
         end
         ST_RPRE: begin
            // load the round input; key 0 (or 31) is being read
            priority case (mode_ff)
               MODE_OFB: x_in = '{chain_hi_ff[63:32], chain_hi_ff[31:0],
                                  chain_lo_ff[63:32], chain_lo_ff[31:0]};
               MODE_CBC: begin
                  if (dec_ff) begin
                     x_in = '{blk_hi_ff[63:32], blk_hi_ff[31:0],
                              blk_lo_ff[63:32], blk_lo_ff[31:0]};
                  end else begin
                     x_in = '{blk_hi_ff[63:32] ^ chain_hi_ff[63:32],
                              blk_hi_ff[31:0] ^ chain_hi_ff[31:0],
                              blk_lo_ff[63:32] ^ chain_lo_ff[63:32],
                              blk_lo_ff[31:0] ^ chain_lo_ff[31:0]};
                  end
               end
               default: x_in = '{blk_hi_ff[63:32], blk_hi_ff[31:0],
                                 blk_lo_ff[63:32], blk_lo_ff[31:0]};
            endcase
            rk_raddr = rev ? 5'd31 : 5'd0;
            cnt_in   = 5'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // round r uses key read last cycle; prefetch key r+1
            x_in   = '{x_ff[1], x_ff[2], x_ff[3], new_word};
            cnt_in = cnt_ff + 5'd1;
            rk_raddr = rev ? ~(cnt_ff + 5'd1) : cnt_ff + 5'd1;
            if (cnt_ff == 5'(RoundCount - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // chaining and output formatting
            priority case (mode_ff)
               MODE_CBC: begin
                  if (dec_ff) begin
                     res_hi = out_blk[127:64] ^ chain_hi_ff;
                     res_lo = out_blk[63:0] ^ chain_lo_ff;
                     chain_hi_in = blk_hi_ff;
                     chain_lo_in = blk_lo_ff;
                  end else begin
                     res_hi = out_blk[127:64];
                     res_lo = out_blk[63:0];
                     chain_hi_in = res_hi;
                     chain_lo_in = res_lo;
                  end
               end
               MODE_OFB: begin
                  res_hi = (blk_hi_ff ^ ofb_ks[127:64])
                         & ((nb_ff >= 5'd8) ? {64{1'b1}} : lead_mask(nb_ff[3:0]));
                  res_lo = (blk_lo_ff ^ ofb_ks[63:0])
                         & ((nb_ff > 5'd8) ? lead_mask(4'(nb_ff - 5'd8)) : 64'd0);
                  if (nb_ff == 5'd16) begin
                     chain_hi_in = ofb_ks[127:64];
                     chain_lo_in = ofb_ks[63:0];
                  end
               end
               default: begin
                  res_hi = out_blk[127:64];
                  res_lo = out_blk[63:0];
               end
            endcase
            rsp_in   = {1'b0, STAT_OK, nb_ff, res_lo, res_hi};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (kwrite) begin
         keys_ready_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         keys_ready_ff <= 1'b0;
         chain_hi_ff   <= '0;
         chain_lo_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_ready_ff <= keys_ready_in;
         chain_hi_ff   <= chain_hi_in;
         chain_lo_ff   <= chain_lo_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         blk_hi_ff <= req_tdata[63:0];
         blk_lo_ff <= req_tdata[127:64];
         nb_ff     <= nb_sat;
      end
   end

   // assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted while busy");
   a_rsp_follows_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> rsp_tvalid)
      else $error("finish did not present a response");
   a_keys_before_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RPRE) |-> keys_ready_ff || $past(kwrite))
      else $error("rounds started without round keys");
   a_err_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[134:133] != STAT_OK) |-> (rsp_tdata[132:0] == '0))
      else $error("error response carries data");
endmodule
`default_nettype wire

[hdl/sm4m_ram.sv]
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module sm4m_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
